// ===== rtl/core/hall_throttle_conditioner_defines.svh =====
// Assertion macros for the hall throttle conditioner checker.
`ifndef HALL_THROTTLE_CONDITIONER_DEFINES_SVH
`define HALL_THROTTLE_CONDITIONER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HTC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htc assertion failed");

// Next-cycle implication, disabled during reset.
`define HTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htc assertion failed");

// Property checked at every edge, reset included.
`define HTC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("htc assertion failed");

`endif

// ===== rtl/core/htc_pkg.sv =====
// Shared types and constants of the hall throttle conditioner.
`timescale 1ns / 1ps
`default_nettype none
package htc_pkg;

  // Field widths
  localparam int SAMPLE_W   = 10;
  localparam int CAL_W      = 10;
  localparam int MARGIN_W   = 7;
  localparam int THR_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  // Widest group sum over the parameter range (10 bits of sample, 16 samples)
  localparam int GRP_SUM_W  = 14;

  // Divider: dividend and divisor widths, two quotient bits per cycle
  localparam int DIV_W      = 18;
  localparam int DEN_W      = 10;

  // Throttle codes
  localparam logic [THR_W-1:0] THR_NEUTRAL = 8'd127;
  localparam logic [THR_W-1:0] THR_FULL    = 8'd255;
  localparam logic [THR_W-1:0] THR_BRAKE   = 8'd0;

  // Register reset values
  localparam logic [CAL_W-1:0]    RST_HALL_MIN    = 10'd0;
  localparam logic [CAL_W-1:0]    RST_HALL_CENTER = 10'd512;
  localparam logic [CAL_W-1:0]    RST_HALL_MAX    = 10'd1023;
  localparam logic [MARGIN_W-1:0] RST_MARGIN      = 7'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALL_MIN      = 2'd0,
    REG_HALL_CENTER   = 2'd1,
    REG_HALL_MAX      = 2'd2,
    REG_CENTER_MARGIN = 2'd3
  } htc_reg_e;

  typedef struct packed {
    logic [CAL_W-1:0]    hall_min;
    logic [CAL_W-1:0]    hall_center;
    logic [CAL_W-1:0]    hall_max;
    logic [MARGIN_W-1:0] center_margin;
  } htc_cfg_t;

  // One finished sample group, queued between front and back
  typedef struct packed {
    logic                 trig;
    logic [GRP_SUM_W-1:0] sum;
  } htc_grp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } htc_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } htc_div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/hall_throttle_conditioner.sv =====
// Top level of the hall throttle conditioner: config registers and datapath.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata: sample; tuser: trigger_active
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata: hall_average, throttle
//   cfg       in   cfg_we_i (no wait)           cfg_idx_i, cfg_data_i
//
// The front takes one sample per cycle while the two-entry group queue has room.
// The back takes a group that needs the span division through reciprocal
// multiply for the average, setup, a radix-4 divide and its done flag,
// output load and return to idle; a group settled without it skips the
// divide. The back takes a new group only once it is back in idle.
// Reset clears counters, queue and output valid and loads the calibration
// defaults. A stalled output holds; the front keeps filling the queue.
`timescale 1ns / 1ps
`default_nettype none
module hall_throttle_conditioner #(
  parameter int AVG_SAMPLES = 10,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // [9:0] sample
  input  logic                            s_axis_tuser,  // [0] trigger_active
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // [9:0] hall_average, [17:10] throttle
  input  logic                            cfg_we_i,
  input  logic [htc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [htc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import htc_pkg::*;

  htc_cfg_t         cfg_q;
  logic             push, push_ready, grp_valid, grp_pop;
  htc_grp_t         push_grp, grp;
  htc_div_req_t     div_req;
  htc_div_rsp_t     div_rsp;
  logic [CAL_W-1:0] hall_average;
  logic [THR_W-1:0] throttle;

  // Write calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hall_min      <= RST_HALL_MIN;
      cfg_q.hall_center   <= RST_HALL_CENTER;
      cfg_q.hall_max      <= RST_HALL_MAX;
      cfg_q.center_margin <= RST_MARGIN;
    end else if (cfg_we_i) begin
      unique case (htc_reg_e'(cfg_idx_i))
        REG_HALL_MIN:      cfg_q.hall_min      <= cfg_data_i[CAL_W-1:0];
        REG_HALL_CENTER:   cfg_q.hall_center   <= cfg_data_i[CAL_W-1:0];
        REG_HALL_MAX:      cfg_q.hall_max      <= cfg_data_i[CAL_W-1:0];
        REG_CENTER_MARGIN: cfg_q.center_margin <= cfg_data_i[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  htc_front #(
    .AVG_SAMPLES (AVG_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .sample_i         (s_axis_tdata[SAMPLE_W-1:0]),
    .trigger_active_i (s_axis_tuser),
    .push_o           (push),
    .grp_o            (push_grp),
    .push_ready_i     (push_ready)
  );

  htc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_grp),
    .push_ready_o (push_ready),
    .pop_i        (grp_pop),
    .pop_valid_o  (grp_valid),
    .pop_data_o   (grp)
  );

  htc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  htc_back #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .grp_valid_i    (grp_valid),
    .grp_i          (grp),
    .grp_pop_o      (grp_pop),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .hall_average_o (hall_average),
    .throttle_o     (throttle)
  );

  // Pack the result
  assign m_axis_tdata = {6'b0, throttle, hall_average};

endmodule
`default_nettype wire

// ===== rtl/core/htc_front.sv =====
// Front end: accepts samples, accumulates each group and queues its sum.
`timescale 1ns / 1ps
`default_nettype none
module htc_front #(
  parameter int AVG_SAMPLES = 10,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [htc_pkg::SAMPLE_W-1:0]      sample_i,
  input  logic                              trigger_active_i,
  output logic                              push_o,
  output htc_pkg::htc_grp_t                 grp_o,
  input  logic                              push_ready_i
);
  import htc_pkg::*;

  localparam int EFF_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int CNT_W    = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
  localparam int SUM_W    = EFF_BITS + CNT_W;

  logic [SUM_W-1:0] sum_q, sum_d, sum_next;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept, last;

  // Add the masked sample and spot the group end
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign sum_next   = sum_q + {{(SUM_W-EFF_BITS){1'b0}}, sample_i[EFF_BITS-1:0]};
  assign last       = (cnt_q == CNT_W'(AVG_SAMPLES - 1));

  assign push_o    = accept && last;
  assign grp_o.sum  = GRP_SUM_W'(sum_next);
  assign grp_o.trig = trigger_active_i;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (last) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/htc_queue.sv =====
// Two-entry queue of finished sample groups between front and back.
`timescale 1ns / 1ps
`default_nettype none
module htc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  htc_pkg::htc_grp_t push_data_i,
  output logic              push_ready_o,
  input  logic              pop_i,
  output logic              pop_valid_o,
  output htc_pkg::htc_grp_t pop_data_o
);
  import htc_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  htc_grp_t           mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]     fill_q;
  logic               do_push, do_pop;

  assign push_ready_o = (fill_q != (PTR_W+1)'(DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Store entry payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/htc_div.sv =====
// Iterative restoring divider, two quotient bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module htc_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  htc_pkg::htc_div_req_t req_i,
  output htc_pkg::htc_div_rsp_t rsp_o
);
  import htc_pkg::*;

  localparam int BITS_PER_CYC = 2;
  localparam int STEPS        = DIV_W / BITS_PER_CYC;
  localparam int CNT_W        = $clog2(STEPS + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  // Two shift-compare-subtract steps
  always_comb begin
    logic [DEN_W:0] trial;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int i = 0; i < BITS_PER_CYC; i++) begin
      trial = {rem_d, quo_d[DIV_W-1]};
      quo_d = {quo_d[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial    = trial - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[DEN_W-1:0];
    end
  end

  // Load operands on start, iterate while busy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/htc_back.sv =====
// Back end: averages a queued group, maps it to throttle, holds the result.
`timescale 1ns / 1ps
`default_nettype none
module htc_back #(
  parameter int AVG_SAMPLES = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  htc_pkg::htc_cfg_t           cfg_i,
  input  logic                        grp_valid_i,
  input  htc_pkg::htc_grp_t           grp_i,
  output logic                        grp_pop_o,
  output htc_pkg::htc_div_req_t       div_req_o,
  input  htc_pkg::htc_div_rsp_t       div_rsp_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [htc_pkg::CAL_W-1:0]   hall_average_o,
  output logic [htc_pkg::THR_W-1:0]   throttle_o
);
  import htc_pkg::*;

  // Reciprocal of the group length, rounded up; exact for any sum below 2**GRP_SUM_W
  localparam int RCP_SH = GRP_SUM_W + $clog2(AVG_SAMPLES);
  localparam int RCP_W  = RCP_SH + 1;
  localparam int PROD_W = GRP_SUM_W + RCP_W;
  localparam longint unsigned RCP_VAL =
    ((64'd1 << RCP_SH) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES);
  localparam logic [RCP_W-1:0] RCP_MUL = RCP_W'(RCP_VAL);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MAP,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [CAL_W-1:0] avg_q;
  logic             trig_q, upper_q;
  logic [THR_W-1:0] thr_q;
  logic             out_valid_q;
  logic [CAL_W-1:0] out_avg_q;
  logic [THR_W-1:0] out_thr_q;

  logic             upper, direct;
  logic [THR_W-1:0] direct_thr, mapped_thr, final_thr, thr_dist;
  logic [CAL_W:0]   up_den, lo_num, lo_den;
  logic [CAL_W-1:0] up_diff, lo_num_mag, lo_den_mag;
  logic [DIV_W-1:0] map_num;
  logic [DEN_W-1:0] map_den;
  logic [PROD_W-1:0] avg_prod;
  logic             load_out;

  // Average the group sum by reciprocal multiplication
  assign avg_prod = PROD_W'(grp_i.sum) * PROD_W'(RCP_MUL);

  // Spans and numerators of the chosen half
  assign upper      = (avg_q >= cfg_i.hall_center);
  assign up_diff    = avg_q - cfg_i.hall_center;
  assign up_den     = {1'b0, cfg_i.hall_max} - {1'b0, cfg_i.hall_center};
  assign lo_num     = {1'b0, avg_q} - {1'b0, cfg_i.hall_min};
  assign lo_den     = {1'b0, cfg_i.hall_center} - {1'b0, cfg_i.hall_min};
  assign lo_num_mag = lo_num[CAL_W] ? CAL_W'(-lo_num) : lo_num[CAL_W-1:0];
  assign lo_den_mag = lo_den[CAL_W] ? CAL_W'(-lo_den) : lo_den[CAL_W-1:0];

  // Cases settled without a division
  always_comb begin
    direct     = 1'b1;
    direct_thr = THR_NEUTRAL;
    map_num    = '0;
    map_den    = '0;
    if (upper) begin
      map_num = DIV_W'({up_diff, 7'b0});
      map_den = up_den[DEN_W-1:0];
      if (up_den == '0) begin
        direct_thr = THR_FULL;
      end else if (up_den[CAL_W]) begin
        // inverted span: quotient is never positive
        direct_thr = THR_NEUTRAL;
      end else begin
        direct = 1'b0;
      end
    end else begin
      map_num = DIV_W'({lo_num_mag, 7'b0}) - DIV_W'(lo_num_mag);
      map_den = lo_den_mag;
      if (lo_den == '0) begin
        direct_thr = THR_NEUTRAL;
      end else if (lo_num[CAL_W] != lo_den[CAL_W]) begin
        // opposite signs: quotient at or below zero clamps to full brake
        direct_thr = THR_BRAKE;
      end else begin
        direct = 1'b0;
      end
    end
  end

  // Clamp the quotient to its half
  always_comb begin
    if (upper_q) begin
      mapped_thr = (div_rsp_i.quo > DIV_W'(128)) ? THR_FULL
                                                 : div_rsp_i.quo[THR_W-1:0] + THR_NEUTRAL;
    end else begin
      mapped_thr = (div_rsp_i.quo > DIV_W'(127)) ? THR_NEUTRAL
                                                 : div_rsp_i.quo[THR_W-1:0];
    end
  end

  // Deadband and released trigger
  assign thr_dist  = (thr_q >= THR_NEUTRAL) ? thr_q - THR_NEUTRAL : THR_NEUTRAL - thr_q;
  assign final_thr = (!trig_q || (thr_dist < {1'b0, cfg_i.center_margin})) ? THR_NEUTRAL
                                                                           : thr_q;

  // Divider requests and queue pop
  always_comb begin
    div_req_o = '0;
    grp_pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        grp_pop_o = grp_valid_i;
      end
      ST_SETUP: begin
        if (!direct) begin
          div_req_o.start = 1'b1;
          div_req_o.num   = map_num;
          div_req_o.den   = map_den;
        end
      end
      ST_MAP, ST_DONE: ;
      default: ;
    endcase
  end

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Sequence one group and hold the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      avg_q       <= '0;
      trig_q      <= 1'b0;
      upper_q     <= 1'b0;
      thr_q       <= '0;
      out_avg_q   <= '0;
      out_thr_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (grp_valid_i) begin
            trig_q  <= grp_i.trig;
            avg_q   <= avg_prod[RCP_SH +: CAL_W];
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          upper_q <= upper;
          if (direct) begin
            thr_q   <= direct_thr;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_MAP;
          end
        end
        ST_MAP: begin
          if (div_rsp_i.done) begin
            thr_q   <= mapped_thr;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            out_avg_q   <= avg_q;
            out_thr_q   <= final_thr;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hall_average_o = out_avg_q;
  assign throttle_o     = out_thr_q;

endmodule
`default_nettype wire

// ===== rtl/core/htc_checker.sv =====
// Port-level checker for the hall throttle conditioner, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "hall_throttle_conditioner_defines.svh"
module htc_checker #(
  parameter int AVG_SAMPLES = 10
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [23:0]                     m_axis_tdata,
  input logic                            cfg_we_i,
  input logic [htc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input logic [htc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import htc_pkg::*;

  localparam int CNT_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;

  logic [MARGIN_W-1:0] margin_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [2:0]          pend_q;
  logic                in_xfer, out_xfer, grp_end;
  logic                out_stall, thr_moved, band_ok;
  logic [THR_W-1:0]    thr, thr_dist;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_xfer  = m_axis_tvalid && m_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign grp_end   = in_xfer && (cnt_q == CNT_W'(AVG_SAMPLES - 1));
  assign thr       = m_axis_tdata[17:10];
  assign thr_dist  = (thr >= THR_NEUTRAL) ? thr - THR_NEUTRAL : THR_NEUTRAL - thr;
  assign thr_moved = m_axis_tvalid && (thr != THR_NEUTRAL);
  assign band_ok   = (thr_dist >= {1'b0, margin_q});

  // Mirror the deadband width and count groups owed to the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= RST_MARGIN;
      cnt_q    <= '0;
      pend_q   <= '0;
    end else begin
      if (cfg_we_i && (htc_reg_e'(cfg_idx_i) == REG_CENTER_MARGIN)) begin
        margin_q <= cfg_data_i[MARGIN_W-1:0];
      end
      if (in_xfer) begin
        cnt_q <= grp_end ? '0 : cnt_q + 1'b1;
      end
      if (grp_end && !out_xfer) begin
        pend_q <= pend_q + 1'b1;
      end else if (out_xfer && !grp_end) begin
        pend_q <= pend_q - 1'b1;
      end
    end
  end

  // A stalled result holds
  `HTC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
  // Reset empties the output
  `HTC_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !m_axis_tvalid)
  // No result without a completed group
  `HTC_ASSERT_IMPL(a_no_extra, clk_i, rst_ni, m_axis_tvalid, pend_q != 3'd0)
  // A non-neutral throttle lies outside the deadband
  `HTC_ASSERT_IMPL(a_deadband, clk_i, rst_ni, thr_moved, band_ok)

endmodule

bind hall_throttle_conditioner htc_checker #(
  .AVG_SAMPLES (AVG_SAMPLES)
) u_htc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_we_i      (cfg_we_i),
  .cfg_idx_i     (cfg_idx_i),
  .cfg_data_i    (cfg_data_i)
);
`default_nettype wire
